### design/point_sort_and_normalize_core_macros.svh
// Assertion macros for the point sort and normalize core.
`ifndef POINT_SORT_AND_NORMALIZE_CORE_MACROS_SVH
`define POINT_SORT_AND_NORMALIZE_CORE_MACROS_SVH
`define PSN_ASSERT_IMPL(label, cond, impl) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (impl)) \
    else $error("assertion failed");
`define PSN_ASSERT_NEXT(label, cond, impl) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (impl)) \
    else $error("assertion failed");
`endif

### design/psn_pkg.sv
// Shared constants and types for the point sort and normalize core.
`default_nettype none
package psn_pkg;
  localparam int MaxPoints = 64;
  localparam int FracBits = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int PtW = 64;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic is_last;
  } load_word_t;
endpackage
`default_nettype wire

### design/psn_if.sv
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface psn_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic is_last;
  modport source (output valid, point_x, point_y, is_last, input ready);
  modport sink (input valid, point_x, point_y, is_last, output ready);
endinterface

interface psn_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic last_out;
  logic divide_error;
  logic overflow;
  modport source (output valid, norm_x, norm_y, last_out, divide_error, overflow,
                  input ready);
  modport sink (input valid, norm_x, norm_y, last_out, divide_error, overflow,
                output ready);
endinterface
`default_nettype wire

### design/psn_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module psn_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/psn_div.sv
// Restoring divider: (|v| << FracBits) / d with the sign of v, one quotient bit per cycle, saturated.
`default_nettype none
module psn_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic        [31:0] den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  import psn_pkg::*;
  localparam int NW = 32 + FracBits;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n_r;
  logic [NW-1:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] d_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic [32:0] trial;
  logic [NW:0] qmag;
  logic [NW:0] qs;

  assign trial = {rem_r[31:0], n_r[NW-1]} - {1'b0, d_r};
  assign busy = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[31];
      n_r <= NW'({(num[31] ? 32'(-num) : 32'(num))}) << FracBits;
      rem_r <= '0;
      q_r <= '0;
      d_r <= den;
    end else if (busy) begin
      n_r <= n_r << 1;
      if (!trial[32]) begin
        rem_r <= trial;
        q_r <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], n_r[NW-1]};
        q_r <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    qmag = {1'b0, q_r};
    qs = neg_r ? (NW+1)'(-qmag) : qmag;
    if (!neg_r && qmag > (NW+1)'(32'h7fffffff)) quo = 32'h7fffffff;
    else if (neg_r && qmag > (NW+1)'(33'h80000000)) quo = 32'h80000000;
    else quo = qs[31:0];
  end
endmodule
`default_nettype wire

### design/psn_front.sv
// Front: accepts points, stores them and tracks count, greatest x and drops.
`default_nettype none
module psn_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  psn_in_if.sink                    in_ch,
  input  wire logic                 back_busy,
  output logic                      we,
  output logic [psn_pkg::IdxW-1:0]  waddr,
  output psn_pkg::point_t           wdata,
  output logic                      set_go,
  output logic [psn_pkg::CntW-1:0]  set_count,
  output logic signed [31:0]        set_gx,
  output logic                      set_drop
);
  import psn_pkg::*;
  logic [CntW-1:0] cnt_r;
  logic signed [31:0] gx_r;
  logic drop_r;
  logic acc, full;

  assign in_ch.ready = !back_busy;
  assign acc = in_ch.valid && in_ch.ready;
  assign full = (cnt_r == CntW'(MaxPoints));
  assign we = acc && !full;
  assign waddr = cnt_r[IdxW-1:0];
  assign wdata = '{x: in_ch.point_x, y: in_ch.point_y};
  assign set_go = acc && in_ch.is_last;
  assign set_count = full ? cnt_r : cnt_r + 1'b1;
  assign set_gx = (!full && in_ch.point_x > gx_r) ? in_ch.point_x : gx_r;
  assign set_drop = drop_r || full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      gx_r <= '0;
      drop_r <= 1'b0;
    end else if (set_go) begin
      cnt_r <= '0;
      gx_r <= '0;
      drop_r <= 1'b0;
    end else if (acc) begin
      cnt_r <= set_count;
      gx_r <= set_gx;
      drop_r <= set_drop;
    end
  end
endmodule
`default_nettype wire

### design/psn_back.sv
// Back: selection-sorts the stored set by scans of the RAM and divides each point.
`default_nettype none
module psn_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 set_go,
  input  wire logic [psn_pkg::CntW-1:0] set_count,
  input  wire logic signed [31:0]   set_gx,
  input  wire logic                 set_drop,
  output logic                      busy,
  output logic [psn_pkg::IdxW-1:0]  raddr,
  input  wire psn_pkg::point_t      rdata,
  psn_out_if.source                 out_ch
);
  import psn_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_PICK = 3'd2,
                         S_DIVX = 3'd3, S_DIVY = 3'd4, S_OUT = 3'd5;
  logic [2:0] st_r;
  logic [CntW-1:0] n_r, emitted_r, scan_r;
  logic signed [31:0] gx_r;
  logic drop_r, derr_r;
  logic [MaxPoints-1:0] used_r;
  logic have_r;
  logic [IdxW-1:0] best_r;
  point_t best_pt_r;
  logic rd_v_r;
  logic [IdxW-1:0] rd_idx_r;
  logic signed [31:0] qx_r;
  logic div_start;
  logic signed [31:0] div_num;
  logic div_busy;
  logic signed [31:0] div_q;
  logic better;
  logic ov_r;
  logic signed [31:0] ox_r, oy_r;
  logic ol_r, od_r, of_r;

  psn_div u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(gx_r),
                 .busy(div_busy), .quo(div_q));

  assign busy = (st_r != S_IDLE);
  assign raddr = scan_r[IdxW-1:0];
  assign div_start = (st_r == S_PICK && !derr_r) || (st_r == S_DIVX && !div_busy &&
                     !derr_r && !ov_r);
  assign div_num = (st_r == S_PICK) ? best_pt_r.x : best_pt_r.y;

  always_comb begin
    // rank: nonneg y before neg; nonneg by x desc, neg by x asc; ties by index
    if (!have_r) begin
      better = 1'b1;
    end else if (rdata.y[31] != best_pt_r.y[31]) begin
      better = !rdata.y[31];
    end else if (!rdata.y[31]) begin
      better = rdata.x > best_pt_r.x;
    end else begin
      better = rdata.x < best_pt_r.x;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.norm_x = ox_r;
  assign out_ch.norm_y = oy_r;
  assign out_ch.last_out = ol_r;
  assign out_ch.divide_error = od_r;
  assign out_ch.overflow = of_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      rd_v_r <= 1'b0;
      used_r <= '0;
      have_r <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      rd_v_r <= (st_r == S_SCAN) && (scan_r < n_r);
      rd_idx_r <= scan_r[IdxW-1:0];
      unique case (st_r)
        S_IDLE: begin
          if (set_go) begin
            n_r <= set_count;
            gx_r <= set_gx;
            drop_r <= set_drop;
            derr_r <= (set_gx <= 0);
            emitted_r <= '0;
            scan_r <= '0;
            used_r <= '0;
            have_r <= 1'b0;
            st_r <= (set_count == '0) ? S_IDLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_v_r && !used_r[rd_idx_r] && better) begin
            have_r <= 1'b1;
            best_r <= rd_idx_r;
            best_pt_r <= rdata;
          end
          if (scan_r < n_r) scan_r <= scan_r + 1'b1;
          else if (!rd_v_r) st_r <= S_PICK;
        end
        S_PICK: begin
          used_r[best_r] <= 1'b1;
          st_r <= S_DIVX;
        end
        S_DIVX: begin
          if (derr_r) begin
            if (!ov_r) begin
              qx_r <= '0;
              st_r <= S_OUT;
            end
          end else if (!div_busy && !ov_r) begin
            qx_r <= div_q;
            st_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (!div_busy) st_r <= S_OUT;
        end
        S_OUT: begin
          ov_r <= 1'b1;
          ox_r <= qx_r;
          oy_r <= derr_r ? '0 : div_q;
          ol_r <= (emitted_r + 1'b1 == n_r);
          od_r <= derr_r;
          of_r <= drop_r;
          emitted_r <= emitted_r + 1'b1;
          have_r <= 1'b0;
          scan_r <= '0;
          st_r <= (emitted_r + 1'b1 == n_r) ? S_IDLE : S_SCAN;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/point_sort_and_normalize_core.sv
// Drain: after its closing point, a set of n points is emitted one result at a time;
// per result a scan of the stored points, one pick, two divides (x then y), one output.
// With no positive x the divides are skipped.
// Throughput: one point per cycle while loading; input stalls while the back end sorts.
// Output stalls lengthen the drain; the RAM scan and bit-serial divider set its pace.
// Reset (synchronous, rst_n low) clears front counters and flags, back state and valid flags; RAM is not cleared.
`default_nettype none
module point_sort_and_normalize_core (
  input  wire logic clk,
  input  wire logic rst_n,
  psn_in_if.sink    in_ch,
  psn_out_if.source out_ch
);
  import psn_pkg::*;
`include "point_sort_and_normalize_core_macros.svh"
  logic we, set_go, set_drop, back_busy;
  logic [IdxW-1:0] waddr, raddr;
  point_t wdata, rdata;
  logic [CntW-1:0] set_count;
  logic signed [31:0] set_gx;

  psn_front u_front (.clk, .rst_n, .in_ch, .back_busy, .we, .waddr, .wdata,
                     .set_go, .set_count, .set_gx, .set_drop);
  psn_ram #(.Width(PtW), .Depth(MaxPoints)) u_ram (.clk, .we, .waddr,
                     .wdata(wdata), .raddr, .rdata(rdata));
  psn_back u_back (.clk, .rst_n, .set_go, .set_count, .set_gx, .set_drop,
                   .busy(back_busy), .raddr, .rdata, .out_ch);

  `PSN_ASSERT_IMPL(a_no_in_when_busy, back_busy, !in_ch.ready)
  `PSN_ASSERT_IMPL(a_derr_zero, out_ch.valid && out_ch.divide_error,
                   out_ch.norm_x == 0 && out_ch.norm_y == 0)
  `PSN_ASSERT_NEXT(a_go_busy, set_go && set_count != 0, back_busy)
endmodule
`default_nettype wire

### test/point_sort_and_normalize_core_tb.sv
// Testbench for the point sort and normalize core: directed and random point sets.
`timescale 1ns / 100ps
module point_sort_and_normalize_core_tb;
  import psn_pkg::*;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic last;
    logic derr;
    logic ovf;
  } norm_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psn_in_if in_ch ();
  psn_out_if out_ch ();

  point_sort_and_normalize_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_t set_points[$];
  logic signed [31:0] set_max_x = '0;
  bit set_dropped = 1'b0;
  norm_word_t norm_expected[$];

  int mismatches = 0;
  int points_sent = 0;
  int words_checked = 0;
  int sets_closed = 0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int rx_wait = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [31:0] scale_to_max(logic signed [31:0] v,
                                                      logic signed [31:0] d);
    longint q;
    q = (longint'(v) * (longint'(1) << FracBits)) / longint'(d);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic void predict_point(point_t p, bit last);
    int up_idx[$];
    int dn_idx[$];
    int order[$];
    int key;
    int j;
    bit derr;
    norm_word_t w;
    if (set_points.size() < MaxPoints) begin
      set_points.insert(set_points.size(), p);
      if (p.x > set_max_x) set_max_x = p.x;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    foreach (set_points[i]) begin
      if (set_points[i].y < 0) dn_idx.insert(dn_idx.size(), i);
      else up_idx.insert(up_idx.size(), i);
    end
    for (int i = 1; i < up_idx.size(); i++) begin
      key = up_idx[i];
      j = i;
      while (j > 0 && set_points[up_idx[j-1]].x < set_points[key].x) begin
        up_idx[j] = up_idx[j-1];
        j--;
      end
      up_idx[j] = key;
    end
    for (int i = 1; i < dn_idx.size(); i++) begin
      key = dn_idx[i];
      j = i;
      while (j > 0 && set_points[dn_idx[j-1]].x > set_points[key].x) begin
        dn_idx[j] = dn_idx[j-1];
        j--;
      end
      dn_idx[j] = key;
    end
    order = {up_idx, dn_idx};
    derr = (set_max_x <= 0);
    foreach (order[i]) begin
      w.nx = derr ? '0 : scale_to_max(set_points[order[i]].x, set_max_x);
      w.ny = derr ? '0 : scale_to_max(set_points[order[i]].y, set_max_x);
      w.last = (i == order.size() - 1);
      w.derr = derr;
      w.ovf = set_dropped;
      norm_expected.insert(norm_expected.size(), w);
    end
    set_points.delete();
    set_max_x = '0;
    set_dropped = 1'b0;
    sets_closed++;
  endfunction

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit last);
    int gap;
    point_t p;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    p.x = x;
    p.y = y;
    predict_point(p, last);
    points_sent++;
  endtask

  task automatic send_set(int n, int mode);
    logic signed [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          x = $signed($urandom());
          y = $signed($urandom());
        end
        1: begin
          x = $signed($urandom_range(0, 8) << $urandom_range(12, 20)) - 32'sh0004_0000;
          y = $signed($urandom_range(0, 8) << $urandom_range(12, 20)) - 32'sh0004_0000;
        end
        default: begin
          x = $signed($urandom_range(0, 3)) - 1;
          y = $signed($urandom_range(0, 3)) - 2;
        end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (norm_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    norm_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (norm_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: x=%h y=%h", out_ch.norm_x, out_ch.norm_y);
      end else begin
        e = norm_expected.pop_front();
        words_checked++;
        if (out_ch.norm_x !== e.nx || out_ch.norm_y !== e.ny || out_ch.last_out !== e.last
            || out_ch.divide_error !== e.derr || out_ch.overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h l=%b de=%b ov=%b got x=%h y=%h l=%b de=%b ov=%b",
                     e.nx, e.ny, e.last, e.derr, e.ovf, out_ch.norm_x, out_ch.norm_y,
                     out_ch.last_out, out_ch.divide_error, out_ch.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready && !no_idle) begin
      rx_wait <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic test_extremes();
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh0000_0001, 32'sh0000_0000, 1'b0);
    send_point(32'shffff_ffff, 32'shffff_ffff, 1'b1);
    send_point(32'sh0001_0000, 32'sh0002_0000, 1'b1);
    send_point(32'sh0000_0001, 32'sh7fff_ffff, 1'b1);
    wait_drained();
  endtask

  task automatic test_no_positive_x();
    send_point(32'sh0000_0000, 32'sh0001_0000, 1'b0);
    send_point(32'shffff_0000, 32'shfffe_0000, 1'b1);
    send_point(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_ties_and_groups();
    send_point(32'sh0002_0000, 32'sh0000_0001, 1'b0);
    send_point(32'sh0002_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0001_0000, 32'shffff_ffff, 1'b0);
    send_point(32'sh0001_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh0003_0000, 32'shffff_0000, 1'b0);
    send_point(32'sh0003_0000, 32'sh0005_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    send_set(MaxPoints, 2);
    wait_drained();
    for (int i = 0; i < MaxPoints + 2; i++)
      send_point($signed($urandom_range(0, 200)) - 100, $signed($urandom()),
                 i == MaxPoints + 1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int n;
    while (points_sent < 305) begin
      no_idle = ($urandom_range(0, 5) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_set(n, $urandom_range(0, 2));
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_back_pressure();
    @(posedge clk);
    hold_cycles <= 400;
    send_set(6, 1);
    send_set(5, 0);
    send_set(4, 2);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_no_positive_x();
    test_ties_and_groups();
    test_store_full();
    test_random_sets();
    test_back_pressure();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    repeat (300) @(posedge clk);
    $display("covered %0d points in %0d sets, %0d result words checked",
             points_sent, sets_closed, words_checked);
    $display("sets included extremes, zero divisor, ties, full store and held output");
    if (mismatches == 0 && norm_expected.size() == 0) begin
      $display("point_sort_and_normalize_core_tb: clean");
    end else begin
      $display("point_sort_and_normalize_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d words outstanding", norm_expected.size());
    $display("point_sort_and_normalize_core_tb: errors");
    $finish;
  end
endmodule
